FILE: rtl/piecewise_linear_interpolation_macros.svh
// Assertion macros shared by the piecewise linear interpolation RTL.
`ifndef PIECEWISE_LINEAR_INTERPOLATION_MACROS_SVH
`define PIECEWISE_LINEAR_INTERPOLATION_MACROS_SVH
`ifndef SYNTHESIS
// Checks that a property holds on every rising edge outside reset.
`define PLI_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error("pli: property failed");
// Checks that a condition never becomes true outside reset.
`define PLI_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
	else $error("pli: forbidden condition seen");
`else
`define PLI_ASSERT(lbl, prop)
`define PLI_ASSERT_NEVER(lbl, cond)
`endif
`endif

FILE: rtl/pli_pkg.sv
// Package of types, constants and helpers for the piecewise linear interpolator.
package pli_pkg;

	localparam int MAX_POINTS = 64;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int SLOT_W     = 6;
	localparam int CNT_W      = 7;
	localparam int POS_W      = 16;
	localparam int VAL_W      = 32;
	localparam int DIVIDEND_W = POS_W + VAL_W;
	localparam int QUO_W      = VAL_W;

	// Opcodes of an input transaction.
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Search record handed from cell to cell along the chain.
	typedef struct packed {
		logic             valid;
		logic             done;
		logic             direct;
		logic [VAL_W-1:0] x;
		logic [POS_W-1:0] pa_pos;
		logic [VAL_W-1:0] pa_val;
		logic [POS_W-1:0] pb_pos;
		logic [VAL_W-1:0] pb_val;
	} pli_rec_t;

	// Index of the last breakpoint in use, with the count clamped to the table.
	function automatic logic [IDX_W-1:0] last_slot(input logic [CNT_W-1:0] cnt);
		logic [IDX_W-1:0] res;
		if (cnt == '0) begin
			res = '0;
		end else if (int'(cnt) > MAX_POINTS) begin
			res = IDX_W'(MAX_POINTS - 1);
		end else begin
			res = IDX_W'(int'(cnt) - 1);
		end
		return res;
	endfunction

endpackage

FILE: rtl/pli_cell.sv
// One breakpoint cell: holds an entry and advances the segment search record.
module pli_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_en,
	input  logic [pli_pkg::POS_W-1:0] wr_pos,
	input  logic [pli_pkg::VAL_W-1:0] wr_val,
	input  logic                    is_first,
	input  logic                    is_last,
	input  pli_pkg::pli_rec_t       rec_in,
	output pli_pkg::pli_rec_t       rec_out
);
	import pli_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [VAL_W-1:0] val_q;
	pli_rec_t         rec_d;
	pli_rec_t         rec_q;
	logic signed [VAL_W-1:0] xs;
	logic signed [VAL_W-1:0] ps;

	// The breakpoint entry is written by a load transaction.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			pos_q <= wr_pos;
			val_q <= wr_val;
		end
	end

	assign xs = $signed(rec_in.x);
	assign ps = $signed({{(VAL_W-POS_W){1'b0}}, pos_q});

	// Decide whether the search ends here, and how. The clamp at the last point in use
	// overrides any segment found by an earlier cell.
	always_comb begin
		rec_d = rec_in;
		if (rec_in.valid && !rec_in.direct) begin
			if (is_first && (xs <= ps)) begin
				rec_d.done   = 1'b1;
				rec_d.direct = 1'b1;
				rec_d.pa_val = val_q;
			end else if (is_last && (xs >= ps)) begin
				rec_d.done   = 1'b1;
				rec_d.direct = 1'b1;
				rec_d.pa_val = val_q;
			end else if (!rec_in.done) begin
				if (is_last || (!is_first && (ps >= xs))) begin
					rec_d.done   = 1'b1;
					rec_d.pb_pos = pos_q;
					rec_d.pb_val = val_q;
				end else begin
					rec_d.pa_pos = pos_q;
					rec_d.pa_val = val_q;
				end
			end
		end
	end

	// Hand the record on to the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else begin
			rec_q <= rec_d;
		end
	end

	assign rec_out = rec_q;

endmodule

FILE: rtl/pli_div.sv
// Serial restoring divider, one quotient bit per cycle.
module pli_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [pli_pkg::DIVIDEND_W-1:0] dividend,
	input  logic [pli_pkg::POS_W-1:0]      divisor,
	output logic                           done,
	output logic [pli_pkg::QUO_W-1:0]      quotient
);
	import pli_pkg::*;

	localparam int STEP_W = $clog2(QUO_W);

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [POS_W-1:0]  rem_q;
	logic [QUO_W-1:0]  sh_q;
	logic [POS_W-1:0]  den_q;
	logic [POS_W:0]    part;
	logic [POS_W:0]    trial;
	logic              q_bit;

	// The quotient fits in QUO_W bits, so the upper dividend bits start as remainder.
	assign part  = {rem_q, sh_q[QUO_W-1]};
	assign trial = part - {1'b0, den_q};
	assign q_bit = !trial[POS_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(QUO_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift one dividend bit in and one quotient bit out per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[DIVIDEND_W-1:QUO_W];
			sh_q  <= dividend[QUO_W-1:0];
			den_q <= divisor;
		end else if (run_q) begin
			rem_q <= q_bit ? trial[POS_W-1:0] : part[POS_W-1:0];
			sh_q  <= {sh_q[QUO_W-2:0], q_bit};
		end
	end

	assign done     = done_q;
	assign quotient = sh_q;

endmodule

FILE: rtl/piecewise_linear_interpolation.sv
// Top level of the piecewise linear interpolator: cell chain, multiplier and divider.
//
// Usage: an input transaction is taken at a rising edge with start high and busy low.
// opcode selects a load (entry_index, entry_position, entry_value written into that
// cell, busy stays low, no result) or a query at query_position.
// A query passes once through the chain of MAX_POINTS cells, one cell per cycle,
// which finds the bracketing breakpoints; clamped answers finish there. Otherwise
// the difference terms are registered, then multiplied, and the quotient is
// formed by a serial divider at one bit per cycle.
// One query is in flight at a time; busy is high until the result, and a new
// transaction may be taken in the cycle in which done is high.
// interpolated_value is valid for the single cycle in which done is high; the
// receiver cannot stall, so the result is simply presented once.
// The user must write point_count through point_count_we/point_count_wdata only
// while idle; the block does not enforce this. Reset clears the control state
// and sets point_count to one; the breakpoint table is undefined until loaded.
module piecewise_linear_interpolation (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       opcode,
	input  logic [pli_pkg::SLOT_W-1:0] entry_index,
	input  logic [pli_pkg::POS_W-1:0]  entry_position,
	input  logic signed [pli_pkg::VAL_W-1:0] entry_value,
	input  logic signed [pli_pkg::VAL_W-1:0] query_position,
	input  logic                       point_count_we,
	input  logic [pli_pkg::CNT_W-1:0]  point_count_wdata,
	output logic                       done,
	output logic signed [pli_pkg::VAL_W-1:0] interpolated_value
);
	import pli_pkg::*;

	`include "piecewise_linear_interpolation_macros.svh"

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_MUL,
		S_DIVST,
		S_DIV
	} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         point_count_q;
	logic [IDX_W-1:0]         last;
	logic                     accept;
	pli_rec_t                 launch;
	pli_rec_t                 chain [MAX_POINTS+1];
	pli_rec_t                 tail;
	logic signed [VAL_W:0]    diff_q;
	logic [POS_W-1:0]         dx_q;
	logic [POS_W-1:0]         den_q;
	logic [VAL_W-1:0]         y0_q;
	logic signed [DIVIDEND_W+1:0] prod_c;
	logic signed [DIVIDEND_W+1:0] prod_q;
	logic                     neg_q;
	logic [DIVIDEND_W+1:0]    mag_c;
	logic                     div_start;
	logic                     div_done;
	logic [QUO_W-1:0]         quo;
	logic signed [VAL_W:0]    sq_c;
	logic signed [VAL_W:0]    sum_c;
	logic signed [VAL_W:0]    dx_full;
	logic                     done_q;
	logic [VAL_W-1:0]         result_q;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign last   = last_slot(point_count_q);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= CNT_W'(1);
		end else if (point_count_we) begin
			point_count_q <= point_count_wdata;
		end
	end

	// Record launched into the first cell by a query transaction.
	always_comb begin
		launch       = '0;
		launch.valid = accept && (opcode == OP_QUERY);
		launch.x     = query_position;
	end

	assign chain[0] = launch;

	// Row of breakpoint cells.
	for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
		pli_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr_en   (accept && (opcode == OP_LOAD) && (int'(entry_index) == k)),
			.wr_pos  (entry_position),
			.wr_val  (entry_value),
			.is_first(k == 0),
			.is_last (int'(last) == k),
			.rec_in  (chain[k]),
			.rec_out (chain[k+1])
		);
	end

	assign tail = chain[MAX_POINTS];

	// Offset of the query within its segment.
	assign dx_full = $signed({tail.x[VAL_W-1], tail.x})
		- $signed({{(VAL_W+1-POS_W){1'b0}}, tail.pa_pos});

	// Product of value step and offset, then its magnitude for the divider.
	assign prod_c = diff_q * $signed({1'b0, dx_q});
	assign mag_c  = neg_q ? (DIVIDEND_W+2)'(-prod_q) : prod_q;

	assign div_start = (state_q == S_DIVST);

	pli_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(mag_c[DIVIDEND_W-1:0]),
		.divisor (den_q),
		.done    (div_done),
		.quotient(quo)
	);

	// Signed quotient added to the left value.
	assign sq_c  = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
	assign sum_c = $signed({y0_q[VAL_W-1], y0_q}) + sq_c;

	// Sequencer with the registered result and strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept && (opcode == OP_QUERY)) begin
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (tail.valid) begin
						if (tail.direct) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					state_q <= S_DIVST;
				end
				S_DIVST: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers along the sequence.
	always_ff @(posedge clk) begin
		if ((state_q == S_SEARCH) && tail.valid) begin
			diff_q   <= $signed({tail.pb_val[VAL_W-1], tail.pb_val})
				- $signed({tail.pa_val[VAL_W-1], tail.pa_val});
			dx_q     <= dx_full[POS_W-1:0];
			den_q    <= tail.pb_pos - tail.pa_pos;
			y0_q     <= tail.pa_val;
			result_q <= tail.pa_val;
		end
		if (state_q == S_MUL) begin
			prod_q <= prod_c;
			neg_q  <= prod_c[DIVIDEND_W+1];
		end
		if ((state_q == S_DIV) && div_done) begin
			result_q <= sum_c[VAL_W-1:0];
		end
	end

	assign done               = done_q;
	assign interpolated_value = $signed(result_q);

	// A result strobe lasts one cycle and only ends a query.
	`PLI_ASSERT(a_done_single, done |=> !done)
	`PLI_ASSERT(a_done_after_busy, done |-> $past(busy))
	`PLI_ASSERT(a_query_busy, (accept && (opcode == OP_QUERY)) |=> busy)
	`PLI_ASSERT_NEVER(a_load_result, $past(accept && (opcode == OP_LOAD)) && busy)

endmodule

FILE: sim/interpolation_checker.sv
`timescale 1ns / 1ps
// Checker for the piecewise linear interpolator: breakpoint mirror, value prediction and comparison.
module interpolation_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic                              opcode,
	input  logic [pli_pkg::SLOT_W-1:0]        entry_index,
	input  logic [pli_pkg::POS_W-1:0]         entry_position,
	input  logic signed [pli_pkg::VAL_W-1:0]  entry_value,
	input  logic signed [pli_pkg::VAL_W-1:0]  query_position,
	input  logic                              point_count_we,
	input  logic [pli_pkg::CNT_W-1:0]         point_count_wdata,
	input  logic                              done,
	input  logic signed [pli_pkg::VAL_W-1:0]  interpolated_value,
	input  logic                              run_over,
	output int                                failures,
	output int                                pending
);
	import pli_pkg::*;

	// Mirror of the breakpoint table and of the point count register.
	logic [POS_W-1:0]        bp_position [MAX_POINTS];
	logic signed [VAL_W-1:0] bp_value [MAX_POINTS];
	logic [CNT_W-1:0]        point_count = CNT_W'(1);

	// Interpolated values still owed by the block, oldest first.
	logic signed [VAL_W-1:0] expected_values [$];
	logic signed [VAL_W-1:0] want;
	int                      mismatch_count = 0;
	bit                      leftovers_reported = 1'b0;

	// Value the block should return for a query at position x.
	function automatic logic signed [VAL_W-1:0] interpolate_at(input logic signed [VAL_W-1:0] x);
		int     n;
		int     last_idx;
		int     seg;
		bit     found;
		longint xq;
		longint x0;
		longint x1;
		longint y0;
		longint y1;
		longint span;
		longint product;
		n = int'(point_count);
		if (n < 1) n = 1;
		if (n > MAX_POINTS) n = MAX_POINTS;
		last_idx = n - 1;
		xq = x;
		x0 = bp_position[0];
		x1 = bp_position[last_idx];
		// Clamp to the end values outside the table's span.
		if (xq <= x0) return bp_value[0];
		if (xq >= x1) return bp_value[last_idx];
		// The first slot from one upwards whose position reaches the query closes the segment.
		found = 1'b0;
		seg = last_idx;
		for (int k = 1; k < last_idx; k++) begin
			x1 = bp_position[k];
			if (!found && x1 >= xq) begin
				seg = k;
				found = 1'b1;
			end
		end
		x0 = bp_position[seg-1];
		x1 = bp_position[seg];
		y0 = bp_value[seg-1];
		y1 = bp_value[seg];
		span = x1 - x0;
		if (span <= 0) return y0[VAL_W-1:0];
		// Signed 64-bit division truncates toward zero, as the block must.
		product = (y1 - y0) * (xq - x0);
		return VAL_W'(y0 + product / span);
	endfunction

	// Results are checked before new transactions are taken in, so ordering is oldest first.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count = CNT_W'(1);
			for (int k = 0; k < MAX_POINTS; k++) begin
				bp_position[k] = '0;
				bp_value[k] = '0;
			end
			expected_values.delete();
			mismatch_count = 0;
			leftovers_reported = 1'b0;
			failures <= 0;
			pending <= 0;
		end else begin
			if (done) begin
				if (expected_values.size() == 0) begin
					$display("%0t: interpolated_value %0d arrived with no query waiting",
						$time, interpolated_value);
					mismatch_count++;
				end else begin
					want = expected_values.pop_front();
					if (interpolated_value !== want) begin
						$display("%0t: interpolated_value expected %0d, got %0d",
							$time, want, interpolated_value);
						mismatch_count++;
					end
				end
			end
			if (point_count_we) point_count = point_count_wdata;
			if (start && !busy) begin
				if (opcode == OP_LOAD) begin
					bp_position[entry_index] = entry_position;
					bp_value[entry_index] = entry_value;
				end else begin
					expected_values.insert(expected_values.size(),
						interpolate_at(query_position));
				end
			end
			// Anything still owed once the run is over counts against it.
			if (run_over && !leftovers_reported) begin
				if (expected_values.size() != 0) begin
					$display("%0t: %0d interpolated values never arrived, next expected %0d",
						$time, expected_values.size(), expected_values[0]);
					mismatch_count += expected_values.size();
				end
				leftovers_reported = 1'b1;
			end
			failures <= mismatch_count;
			pending <= expected_values.size();
		end
	end

endmodule

FILE: sim/piecewise_linear_interpolation_tb.sv
`timescale 1ns / 1ps
// Testbench top for the piecewise linear interpolator: clock, reset, stimulus and verdict.
module piecewise_linear_interpolation_tb;
	import pli_pkg::*;

	localparam int SETTLE_CYCLES  = MAX_POINTS + QUO_W + 10;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_ITEMS   = 480;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    opcode = OP_LOAD;
	logic [SLOT_W-1:0]       entry_index = '0;
	logic [POS_W-1:0]        entry_position = '0;
	logic signed [VAL_W-1:0] entry_value = '0;
	logic signed [VAL_W-1:0] query_position = '0;
	logic                    point_count_we = 1'b0;
	logic [CNT_W-1:0]        point_count_wdata = '0;
	logic                    busy;
	logic                    done;
	logic signed [VAL_W-1:0] interpolated_value;
	logic                    run_over = 1'b0;
	int                      failures;
	int                      pending;

	// Stimulus bookkeeping: positions as loaded, the count in effect and tallies.
	logic [POS_W-1:0]        known_pos [MAX_POINTS];
	int                      active_points = 1;
	int                      loads_sent = 0;
	int                      queries_sent = 0;
	int                      counts_written = 0;
	int                      quiet_cycles = 0;
	bit                      steady = 1'b0;

	piecewise_linear_interpolation uut (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.opcode             (opcode),
		.entry_index        (entry_index),
		.entry_position     (entry_position),
		.entry_value        (entry_value),
		.query_position     (query_position),
		.point_count_we     (point_count_we),
		.point_count_wdata  (point_count_wdata),
		.done               (done),
		.interpolated_value (interpolated_value)
	);

	interpolation_checker checker_i (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.opcode             (opcode),
		.entry_index        (entry_index),
		.entry_position     (entry_position),
		.entry_value        (entry_value),
		.query_position     (query_position),
		.point_count_we     (point_count_we),
		.point_count_wdata  (point_count_wdata),
		.done               (done),
		.interpolated_value (interpolated_value),
		.run_over           (run_over),
		.failures           (failures),
		.pending            (pending)
	);

	// Clock with a 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog: ends the run if no transaction of any kind happens for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || point_count_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("piecewise_linear_interpolation_tb NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Breakpoint value with the extremes drawn now and then.
	function automatic logic signed [VAL_W-1:0] pick_value();
		logic signed [VAL_W-1:0] v;
		case ($urandom_range(9, 0))
			0:       v = 32'sh8000_0000;
			1:       v = 32'sh7FFF_FFFF;
			default: v = $urandom();
		endcase
		return v;
	endfunction

	// Query position: mostly inside the loaded span, some on breakpoints, some anywhere.
	function automatic logic signed [VAL_W-1:0] pick_query();
		int r;
		int lo;
		int hi;
		r = $urandom_range(99, 0);
		lo = int'(known_pos[0]);
		hi = int'(known_pos[active_points-1]);
		if (hi < lo) begin
			lo = hi;
			hi = int'(known_pos[0]);
		end
		if (r < 15) return int'(known_pos[$urandom_range(active_points-1, 0)]);
		if (r < 30) return $urandom();
		return lo - 8 + int'($urandom_range(hi - lo + 16, 0));
	endfunction

	// Presents one transaction after random idle cycles and holds it until it is taken.
	task automatic send_item(input logic op, input logic [SLOT_W-1:0] idx,
			input logic [POS_W-1:0] pos, input logic signed [VAL_W-1:0] val,
			input logic signed [VAL_W-1:0] qpos);
		bit taken;
		while (!steady && $urandom_range(99, 0) < 11) begin
			start <= 1'b0;
			opcode <= 1'($urandom());
			entry_index <= SLOT_W'($urandom());
			entry_position <= POS_W'($urandom());
			entry_value <= $urandom();
			query_position <= $urandom();
			@(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		entry_index <= idx;
		entry_position <= pos;
		entry_value <= val;
		query_position <= qpos;
		// Busy is sampled mid-cycle, where it holds the value seen by the next edge.
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end
	endtask

	task automatic send_load(input logic [SLOT_W-1:0] idx, input logic [POS_W-1:0] pos,
			input logic signed [VAL_W-1:0] val);
		known_pos[idx] = pos;
		loads_sent++;
		send_item(OP_LOAD, idx, pos, val, $urandom());
	endtask

	task automatic send_query(input logic signed [VAL_W-1:0] qpos);
		queries_sent++;
		send_item(OP_QUERY, SLOT_W'($urandom()), POS_W'($urandom()), $urandom(), qpos);
	endtask

	// Holds off until every result is in, then lets the block's latency run out.
	task automatic settle();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0 || busy) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the point count while the block is idle.
	task automatic write_count(input logic [CNT_W-1:0] value);
		settle();
		point_count_we <= 1'b1;
		point_count_wdata <= value;
		@(posedge clk);
		point_count_we <= 1'b0;
		if (value == 0) active_points = 1;
		else if (int'(value) > MAX_POINTS) active_points = MAX_POINTS;
		else active_points = int'(value);
		counts_written++;
	endtask

	// Loads slots 0 to n-1, either in ascending position order or in any order.
	task automatic load_points(input int n, input bit ordered);
		int budget;
		int p;
		budget = 65535 / n;
		p = $urandom_range(budget, 0);
		for (int k = 0; k < n; k++) begin
			if (ordered) begin
				send_load(SLOT_W'(k), POS_W'(p), pick_value());
				p += $urandom_range(budget, 0);
			end else begin
				send_load(SLOT_W'(k), POS_W'($urandom()), pick_value());
			end
		end
	endtask

	initial begin
		int phase;
		int items_random;
		int cnt;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill every slot so that no query can read an empty one; the widest swings sit low.
		for (int k = 0; k < MAX_POINTS; k++) begin
			if (k == 1) send_load(SLOT_W'(k), POS_W'(k * 1000), 32'sh8000_0000);
			else if (k == 0 || k == 2) send_load(SLOT_W'(k), POS_W'(k * 1000), 32'sh7FFF_FFFF);
			else send_load(SLOT_W'(k), POS_W'(k * 1000), pick_value());
		end

		// With the count out of reset there is a single breakpoint.
		send_query(32'sh8000_0000);
		send_query(32'sh7FFF_FFFF);
		send_query(500);

		// Full table: both clamps, exact breakpoints and the steepest segments.
		write_count(CNT_W'(MAX_POINTS));
		send_query(32'sh8000_0000);
		send_query(0);
		send_query(1);
		send_query(1000);
		send_query(1500);
		send_query(2999);
		send_query(62999);
		send_query(63000);
		send_query(32'sh7FFF_FFFF);

		// Two points spanning the whole position range, rising and then falling.
		write_count(CNT_W'(2));
		send_load(SLOT_W'(0), 16'd0, 32'sh8000_0000);
		send_load(SLOT_W'(1), 16'hFFFF, 32'sh7FFF_FFFF);
		send_query(1);
		send_query(32768);
		send_query(65534);
		send_query(65535);
		send_load(SLOT_W'(0), 16'd0, 32'sh7FFF_FFFF);
		send_load(SLOT_W'(1), 16'hFFFF, 32'sh8000_0000);
		send_query(1);
		send_query(65534);

		// A count of zero acts as one; one above the table acts as the full table,
		// which now has its positions out of order after the reloads above.
		write_count(CNT_W'(0));
		send_query(12345);
		send_query(-1);
		write_count(7'h7F);
		send_query(30000);
		send_query(63000);
		send_query(64000);

		// Random phases: a count, a fresh table, then mostly queries with a few reloads.
		phase = 0;
		items_random = 0;
		while (items_random < RANDOM_ITEMS) begin
			steady = (phase == 3 || phase == 4);
			if (phase == 0) cnt = MAX_POINTS;
			else if (phase == 1) cnt = 1;
			else if ($urandom_range(99, 0) < 10) cnt = $urandom_range(1, 0) ? 0 : $urandom_range(127, 65);
			else if ($urandom_range(1, 0)) cnt = $urandom_range(8, 2);
			else cnt = $urandom_range(MAX_POINTS, 2);
			write_count(CNT_W'(cnt));
			load_points(active_points, $urandom_range(99, 0) < 80);
			items_random += active_points;
			for (int k = 0; k < 40; k++) begin
				if (k == 20 && phase % 3 == 2) settle();
				if ($urandom_range(99, 0) < 15)
					send_load(SLOT_W'($urandom()), POS_W'($urandom()), pick_value());
				else
					send_query(pick_query());
			end
			items_random += 40;
			phase++;
		end

		// Drain, report leftovers, then give the verdict.
		settle();
		run_over <= 1'b1;
		@(posedge clk);
		@(posedge clk);
		$display("Covered %0d breakpoint loads and %0d queries over %0d point count settings,",
			loads_sent, queries_sent, counts_written);
		$display("including clamping at both ends, single-point, out-of-range and unordered tables.");
		if (failures == 0) begin
			$display("piecewise_linear_interpolation_tb OK");
		end else begin
			$display("piecewise_linear_interpolation_tb NOT OK");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/pli_pkg.sv
rtl/pli_cell.sv
rtl/pli_div.sv
rtl/piecewise_linear_interpolation.sv
sim/interpolation_checker.sv
sim/piecewise_linear_interpolation_tb.sv
